[rtl/core/mfbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit packer package
// Shared opcodes, widths and the job record that passes from the front end
// through the job queue to the byte emitter.
// ----------------------------------------------------------------------------
package mfbp_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam int VALUE_BITS     = 32;
	localparam int COUNT_BITS     = 6;
	localparam int BYTE_BITS      = 8;
	localparam int PEND_BITS      = BYTE_BITS - 1;
	localparam int PCNT_BITS      = 3;
	localparam int MAX_WRITE_BITS = 32;
	localparam int WRITE_CAP      = (MAX_WRITE_BITS < VALUE_BITS) ? MAX_WRITE_BITS : VALUE_BITS;

	// Pending bits plus one full write, right aligned.
	localparam int WORD_BITS  = VALUE_BITS + PEND_BITS;
	localparam int ALIGN_BITS = WORD_BITS + 1;
	localparam int EMIT_BITS  = 4 * BYTE_BITS;
	localparam int NB_BITS    = 3;

	typedef struct packed {
		logic [WORD_BITS-1:0]  word;
		logic [COUNT_BITS-1:0] total;
		logic [NB_BITS-1:0]    nbytes;
	} job_t;

endpackage

[rtl/core/mfbp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit packer front end
// Accepts write and flush transactions, merges them with the pending partial
// byte and hands every transaction that yields bytes to the job queue.
// ----------------------------------------------------------------------------
module mfbp_front
	import mfbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [COUNT_BITS-1:0] bit_count,
	input  logic                  q_full,
	output logic                  push,
	output job_t                  push_job
);

	logic [PEND_BITS-1:0]  pend_bits_q;
	logic [PCNT_BITS-1:0]  pend_cnt_q;
	logic [COUNT_BITS-1:0] n_eff;
	logic [VALUE_BITS-1:0] value_masked;
	logic [WORD_BITS-1:0]  merged;
	logic [COUNT_BITS-1:0] total;
	logic [PEND_BITS-1:0]  keep_mask;
	logic                  accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign n_eff        = (bit_count > COUNT_BITS'(WRITE_CAP)) ? COUNT_BITS'(WRITE_CAP) : bit_count;
	assign value_masked = value & ~({VALUE_BITS{1'b1}} << n_eff);
	assign merged       = (WORD_BITS'(pend_bits_q) << n_eff) | WORD_BITS'(value_masked);
	assign total        = COUNT_BITS'(pend_cnt_q) + n_eff;
	assign keep_mask    = PEND_BITS'((BYTE_BITS'(1) << total[PCNT_BITS-1:0]) - BYTE_BITS'(1));

	always_comb begin
		if (opcode == OP_FLUSH) begin
			// The padding falls out of left aligning a short byte in the emitter.
			push_job.word   = WORD_BITS'(pend_bits_q);
			push_job.total  = COUNT_BITS'(pend_cnt_q);
			push_job.nbytes = NB_BITS'(1);
			push            = accept;
		end else begin
			push_job.word   = merged;
			push_job.total  = total;
			push_job.nbytes = total[COUNT_BITS-1:PCNT_BITS];
			push            = accept && (total[COUNT_BITS-1:PCNT_BITS] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (accept) begin
			if (opcode == OP_FLUSH) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end else begin
				pend_bits_q <= merged[PEND_BITS-1:0] & keep_mask;
				pend_cnt_q  <= total[PCNT_BITS-1:0];
			end
		end
	end

endmodule

[rtl/core/mfbp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit packer job queue
// Short first-in first-out store of jobs between the front end and the
// byte emitter.
// ----------------------------------------------------------------------------
module mfbp_queue
	import mfbp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/core/mfbp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit packer byte emitter
// Left aligns each job and sends its bytes one per cycle, unless out_stall holds them,
// through an output register, marking the final byte of the job.
// ----------------------------------------------------------------------------
module mfbp_back
	import mfbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  job_t                 head_job,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_BITS-1:0] out_byte,
	output logic                 last
);

	logic [EMIT_BITS-1:0]  data_q;
	logic [NB_BITS-1:0]    rem_q;
	logic                  busy_q;
	logic [BYTE_BITS-1:0]  out_byte_q;
	logic                  last_q;
	logic                  out_valid_q;
	logic                  emit;
	logic                  final_byte;
	logic [COUNT_BITS-1:0] shamt;
	logic [ALIGN_BITS-1:0] aligned;

	assign emit       = busy_q && (!out_valid_q || !out_stall);
	assign final_byte = (rem_q == NB_BITS'(1));
	// A new job is loaded as the last byte of the current one leaves.
	assign pop        = head_valid && (!busy_q || (emit && final_byte));

	assign shamt   = COUNT_BITS'(ALIGN_BITS) - head_job.total;
	assign aligned = ALIGN_BITS'(head_job.word) << shamt;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= aligned[ALIGN_BITS-1 -: EMIT_BITS];
		end else if (emit) begin
			data_q <= data_q << BYTE_BITS;
		end
		if (emit) begin
			out_byte_q <= data_q[EMIT_BITS-1 -: BYTE_BITS];
			last_q     <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				rem_q  <= head_job.nbytes;
			end else if (emit) begin
				busy_q <= !final_byte;
				rem_q  <= rem_q - NB_BITS'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/msb_first_bit_packer.sv]
`timescale 1ns / 1ps
// Path: each byte passes through the job queue, the data register and the output register.
// Throughput: one input transaction per cycle while the job queue has room; the output side
// delivers one byte per cycle while out_stall is low, so a write that completes several
// bytes keeps the emitter busy and the queue of QUEUE_DEPTH jobs absorbs the difference.
// Reset: asynchronous, clears the pending partial byte, the queue and the output valid flag.
// ----------------------------------------------------------------------------
// MSB-first bit packer
// Packs variable-length codes into bytes, first bit in bit 7, with a flush
// that pads the partial byte with zeros.
// ----------------------------------------------------------------------------
module msb_first_bit_packer
	import mfbp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [COUNT_BITS-1:0] bit_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [BYTE_BITS-1:0]  out_byte,
	output logic                  last
);

	logic q_full;
	logic q_push;
	job_t q_push_job;
	logic q_pop;
	logic q_head_valid;
	job_t q_head_job;

	mfbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.value    (value),
		.bit_count(bit_count),
		.q_full   (q_full),
		.push     (q_push),
		.push_job (q_push_job)
	);

	mfbp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_push_job),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_head_valid),
		.head_job  (q_head_job)
	);

	mfbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_head_valid),
		.head_job  (q_head_job),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

	a_flush_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == OP_FLUSH) |-> q_push)
		else $error("flush transaction did not enter the job queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into a full queue");

	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("job popped from an empty queue");

	a_job_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> out_valid)
		else $error("gap between bytes of one job");

endmodule
